/* sv/best_fit_heap_allocator_assert.svh */
// assertion macros for the best-fit heap allocator
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define BFHA_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
// antecedent on one edge forces consequent on the next
`define BFHA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");
`else
`define BFHA_ALWAYS(lbl, cond)
`define BFHA_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/bfha_pkg.sv */
package bfha_pkg;

    localparam int OFF_W = 26;
    localparam int LEN_W = 27;
    localparam logic [LEN_W-1:0] HEAP_CAP = LEN_W'(1) << OFF_W;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] request_bytes;
        logic [OFF_W-1:0] block_offset;
    } in_word_t;

    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] granted_offset;
        logic [LEN_W-1:0] bytes_remaining;
        logic [LEN_W-1:0] largest_free;
    } out_word_t;

    // one section of the heap: start offset and length
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_NEXT,
        CELL_TAKE_PREV,
        CELL_LOAD
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_USCAN,
        S_FREE_RM,
        S_FSCAN,
        S_ALLOC_UPD,
        S_FREE_INS,
        S_LSCAN,
        S_DONE
    } state_t;

endpackage

/* sv/bfha_cell.sv */
module bfha_cell (
    input  logic              clk,
    input  bfha_pkg::cell_op_t cmd,
    input  bfha_pkg::entry_t  next_entry,
    input  bfha_pkg::entry_t  prev_entry,
    input  bfha_pkg::entry_t  load_entry,
    output bfha_pkg::entry_t  entry
);
    import bfha_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        unique case (cmd)
            CELL_HOLD:      entry_next = entry_reg;
            CELL_TAKE_NEXT: entry_next = next_entry;
            CELL_TAKE_PREV: entry_next = prev_entry;
            CELL_LOAD:      entry_next = load_entry;
            default:        entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* sv/best_fit_heap_allocator.sv */
// best-fit heap allocator with coalescing free list
// input channel in_valid/in_ready carries one request word (allocate or free);
// output channel out_valid/out_ready carries one result word per request.
// heap size is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block does not enforce; a write resets
// the tables to one free section covering the whole heap. free sections
// (MAX_BLOCKS+1 cells) and allocated blocks (MAX_BLOCKS cells) sit in two
// rings of cells; a search rotates a ring one full turn past a scan unit at
// its head, edits are done by the cells in parallel, each taking a neighbor's
// entry or a new one. allocate: free turn for best fit, update, free turn for
// largest; free: used turn for lookup, removal, free turn for insert point,
// insertion, free turn for largest; a rejected request skips the edits.
// one request is in work at a time; the next is taken as soon as the result
// is parked in the output register, so a stalled receiver costs nothing
// until a second result is ready.
// reset: heap size 0, no sections, no blocks; output register empty.
module best_fit_heap_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bfha_pkg::in_word_t      in_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bfha_pkg::out_word_t     out_word,
    input  logic                    cfg_we,
    input  logic [bfha_pkg::LEN_W-1:0] cfg_wdata
);
    import bfha_pkg::*;

    localparam int FD = MAX_BLOCKS + 1;
    localparam int MB = MAX_BLOCKS;
    localparam int CW = $clog2(FD + 1);

    // cell rings
    entry_t   fcell [FD];
    cell_op_t fop   [FD];
    entry_t   fload [FD];
    entry_t   ucell [MB];
    cell_op_t uop   [MB];
    entry_t   uload [MB];

    for (genvar g = 0; g < FD; g++)
    begin : g_free
        bfha_cell u_cell (
            .clk        (clk),
            .cmd        (fop[g]),
            .next_entry (fcell[(g + 1) % FD]),
            .prev_entry (fcell[(g + FD - 1) % FD]),
            .load_entry (fload[g]),
            .entry      (fcell[g])
        );
    end

    for (genvar g = 0; g < MB; g++)
    begin : g_used
        bfha_cell u_cell (
            .clk        (clk),
            .cmd        (uop[g]),
            .next_entry (ucell[(g + 1) % MB]),
            .prev_entry (ucell[(g + MB - 1) % MB]),
            .load_entry (uload[g]),
            .entry      (ucell[g])
        );
    end

    // control state
    state_t           state_reg,   state_next;
    logic [CW-1:0]    step_reg,    step_next;
    logic [CW-1:0]    fcount_reg,  fcount_next;
    logic [CW-1:0]    ucount_reg,  ucount_next;
    logic [LEN_W-1:0] remain_reg,  remain_next;
    logic [LEN_W-1:0] heap_reg,    heap_next;
    logic             found_reg,   found_next;
    logic             out_valid_reg, out_valid_next;
    // working registers
    in_word_t         req_reg,     req_next;
    status_t          status_reg,  status_next;
    logic [OFF_W-1:0] granted_reg, granted_next;
    logic [CW-1:0]    idx_reg,     idx_next;
    logic [OFF_W-1:0] hit_start_reg, hit_start_next;
    logic [LEN_W-1:0] hit_len_reg, hit_len_next;
    logic [LEN_W-1:0] least_reg,   least_next;
    logic [LEN_W-1:0] ulen_reg,    ulen_next;
    logic [OFF_W-1:0] prev_start_reg, prev_start_next;
    logic [LEN_W-1:0] prev_len_reg, prev_len_next;
    logic [LEN_W-1:0] largest_reg, largest_next;
    out_word_t        out_reg,     out_next;

    logic [LEN_W-1:0] waste;
    logic [LEN_W-1:0] prev_end;
    logic [LEN_W-1:0] blk_end;
    logic [LEN_W-1:0] cfg_cap;
    logic             left_m;
    logic             right_m;
    logic             last_f;
    logic             last_u;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        fcount_next     = fcount_reg;
        ucount_next     = ucount_reg;
        remain_next     = remain_reg;
        heap_next       = heap_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;
        req_next        = req_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        idx_next        = idx_reg;
        hit_start_next  = hit_start_reg;
        hit_len_next    = hit_len_reg;
        least_next      = least_reg;
        ulen_next       = ulen_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        largest_next    = largest_reg;
        out_next        = out_reg;
        for (int i = 0; i < FD; i++)
        begin
            fop[i]   = CELL_HOLD;
            fload[i] = '0;
        end
        for (int i = 0; i < MB; i++)
        begin
            uop[i]   = CELL_HOLD;
            uload[i] = '0;
        end

        last_f   = (step_reg == CW'(FD - 1));
        last_u   = (step_reg == CW'(MB - 1));
        waste    = fcell[0].len - req_reg.request_bytes;
        prev_end = {1'b0, prev_start_reg} + prev_len_reg;
        blk_end  = {1'b0, req_reg.block_offset} + ulen_reg;
        left_m   = (idx_reg != '0) && (prev_end == {1'b0, req_reg.block_offset});
        right_m  = (idx_reg < fcount_reg) && (blk_end == {1'b0, hit_start_reg});
        cfg_cap  = (cfg_wdata > HEAP_CAP) ? HEAP_CAP : cfg_wdata;

        // result register drains independently of the sequencer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_word;
                    status_next  = ST_OK;
                    granted_next = '0;
                    step_next    = '0;
                    found_next   = 1'b0;
                    if (in_word.op == OP_FREE)
                    begin
                        state_next = S_USCAN;
                    end
                    else if (in_word.request_bytes == '0 ||
                             in_word.request_bytes > remain_reg)
                    begin
                        status_next = ST_NO_FIT;
                        state_next  = S_LSCAN;
                    end
                    else
                    begin
                        state_next = S_FSCAN;
                    end
                end
            end

            S_USCAN:
            begin
                for (int i = 0; i < MB; i++)
                begin
                    uop[i] = CELL_TAKE_NEXT;
                end
                if (step_reg < ucount_reg && !found_reg &&
                    ucell[0].start == req_reg.block_offset)
                begin
                    found_next = 1'b1;
                    idx_next   = step_reg;
                    ulen_next  = ucell[0].len;
                end
                step_next = step_reg + 1'b1;
                if (last_u)
                begin
                    step_next = '0;
                    if (found_next)
                    begin
                        state_next = S_FREE_RM;
                    end
                    else
                    begin
                        status_next = ST_NOT_ALLOC;
                        state_next  = S_LSCAN;
                    end
                end
            end

            S_FREE_RM:
            begin
                for (int i = 0; i < MB; i++)
                begin
                    if (CW'(i) >= idx_reg)
                    begin
                        uop[i] = CELL_TAKE_NEXT;
                    end
                end
                ucount_next = ucount_reg - 1'b1;
                remain_next = remain_reg + ulen_reg;
                found_next  = 1'b0;
                step_next   = '0;
                state_next  = S_FSCAN;
            end

            S_FSCAN:
            begin
                for (int i = 0; i < FD; i++)
                begin
                    fop[i] = CELL_TAKE_NEXT;
                end
                if (step_reg < fcount_reg)
                begin
                    if (req_reg.op == OP_ALLOC)
                    begin
                        // least waste, first found wins ties
                        if (fcell[0].len >= req_reg.request_bytes &&
                            (!found_reg || waste < least_reg))
                        begin
                            found_next     = 1'b1;
                            least_next     = waste;
                            idx_next       = step_reg;
                            hit_start_next = fcell[0].start;
                            hit_len_next   = fcell[0].len;
                        end
                    end
                    else if (!found_reg)
                    begin
                        // insertion point: first section at or above the offset
                        if (fcell[0].start < req_reg.block_offset)
                        begin
                            prev_start_next = fcell[0].start;
                            prev_len_next   = fcell[0].len;
                        end
                        else
                        begin
                            found_next     = 1'b1;
                            idx_next       = step_reg;
                            hit_start_next = fcell[0].start;
                            hit_len_next   = fcell[0].len;
                        end
                    end
                end
                step_next = step_reg + 1'b1;
                if (last_f)
                begin
                    step_next = '0;
                    if (req_reg.op == OP_ALLOC)
                    begin
                        state_next = S_ALLOC_UPD;
                    end
                    else
                    begin
                        if (!found_next)
                        begin
                            idx_next = fcount_reg;
                        end
                        state_next = S_FREE_INS;
                    end
                end
            end

            S_ALLOC_UPD:
            begin
                state_next = S_LSCAN;
                if (!found_reg)
                begin
                    status_next = ST_NO_FIT;
                end
                else if (ucount_reg >= CW'(MB))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    granted_next = hit_start_reg;
                    for (int i = 0; i < MB; i++)
                    begin
                        if (CW'(i) == ucount_reg)
                        begin
                            uop[i]   = CELL_LOAD;
                            uload[i] = '{start: hit_start_reg, len: req_reg.request_bytes};
                        end
                    end
                    ucount_next = ucount_reg + 1'b1;
                    remain_next = remain_reg - req_reg.request_bytes;
                    if (hit_len_reg == req_reg.request_bytes)
                    begin
                        for (int i = 0; i < FD; i++)
                        begin
                            if (CW'(i) >= idx_reg)
                            begin
                                fop[i] = CELL_TAKE_NEXT;
                            end
                        end
                        fcount_next = fcount_reg - 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < FD; i++)
                        begin
                            if (CW'(i) == idx_reg)
                            begin
                                fop[i]   = CELL_LOAD;
                                fload[i] = '{
                                    start: hit_start_reg + OFF_W'(req_reg.request_bytes),
                                    len:   hit_len_reg - req_reg.request_bytes};
                            end
                        end
                    end
                end
            end

            S_FREE_INS:
            begin
                state_next = S_LSCAN;
                for (int i = 0; i < FD; i++)
                begin
                    if (left_m && right_m)
                    begin
                        // block bridges two sections
                        if (CW'(i + 1) == idx_reg)
                        begin
                            fop[i]   = CELL_LOAD;
                            fload[i] = '{start: prev_start_reg,
                                         len: prev_len_reg + ulen_reg + hit_len_reg};
                        end
                        else if (CW'(i) >= idx_reg)
                        begin
                            fop[i] = CELL_TAKE_NEXT;
                        end
                    end
                    else if (left_m)
                    begin
                        if (CW'(i + 1) == idx_reg)
                        begin
                            fop[i]   = CELL_LOAD;
                            fload[i] = '{start: prev_start_reg, len: prev_len_reg + ulen_reg};
                        end
                    end
                    else if (right_m)
                    begin
                        if (CW'(i) == idx_reg)
                        begin
                            fop[i]   = CELL_LOAD;
                            fload[i] = '{start: req_reg.block_offset,
                                         len: hit_len_reg + ulen_reg};
                        end
                    end
                    else if (fcount_reg < CW'(FD))
                    begin
                        if (CW'(i) == idx_reg)
                        begin
                            fop[i]   = CELL_LOAD;
                            fload[i] = '{start: req_reg.block_offset, len: ulen_reg};
                        end
                        else if (CW'(i) > idx_reg)
                        begin
                            fop[i] = CELL_TAKE_PREV;
                        end
                    end
                end
                if (left_m && right_m)
                begin
                    fcount_next = fcount_reg - 1'b1;
                end
                else if (!left_m && !right_m && fcount_reg < CW'(FD))
                begin
                    fcount_next = fcount_reg + 1'b1;
                end
            end

            S_LSCAN:
            begin
                for (int i = 0; i < FD; i++)
                begin
                    fop[i] = CELL_TAKE_NEXT;
                end
                largest_next = (step_reg == '0) ? '0 : largest_reg;
                if (step_reg < fcount_reg && fcell[0].len > largest_next)
                begin
                    largest_next = fcell[0].len;
                end
                step_next = step_reg + 1'b1;
                if (last_f)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status          = status_reg;
                    out_next.granted_offset  = granted_reg;
                    out_next.bytes_remaining = remain_reg;
                    out_next.largest_free    = largest_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // heap size write reinitializes both tables
        if (cfg_we)
        begin
            heap_next   = cfg_cap;
            remain_next = cfg_cap;
            ucount_next = '0;
            fcount_next = (cfg_cap != '0) ? CW'(1) : '0;
            fop[0]      = CELL_LOAD;
            fload[0]    = '{start: '0, len: cfg_cap};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            fcount_reg    <= '0;
            ucount_reg    <= '0;
            remain_reg    <= '0;
            heap_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fcount_reg    <= fcount_next;
            ucount_reg    <= ucount_next;
            remain_reg    <= remain_next;
            heap_reg      <= heap_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        idx_reg        <= idx_next;
        hit_start_reg  <= hit_start_next;
        hit_len_reg    <= hit_len_next;
        least_reg      <= least_next;
        ulen_reg       <= ulen_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        largest_reg    <= largest_next;
        out_reg        <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`include "best_fit_heap_allocator_assert.svh"

    `BFHA_ALWAYS(a_fcount_max, fcount_reg <= CW'(FD))
    `BFHA_ALWAYS(a_ucount_max, ucount_reg <= CW'(MB))
    `BFHA_ALWAYS(a_remain_le_heap, remain_reg <= heap_reg)
    `BFHA_NEXT(a_lscan_done, state_reg == S_LSCAN && last_f, state_reg == S_DONE)

endmodule
